### rtl/assert_macros.svh
// Assertion macros shared by the LCD nibble write sequencer modules.
// No dependencies; each user module provides clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define LCDNWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define LCDNWS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LCDNWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lcdnws_pkg.sv
// Types, constants and the microcode table for the LCD nibble write sequencer.
// No dependencies.
package lcdnws_pkg;

  // Request opcodes
  localparam logic [1:0] OP_CMD    = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;
  localparam logic [1:0] OP_INIT   = 2'd3;

  // Cursor addressing
  localparam logic [1:0] ROW_FIRST      = 2'd1;
  localparam logic [7:0] ROW_FIRST_BASE = 8'h7F;
  localparam logic [7:0] ROW_OTHER_BASE = 8'hBF;

  // Hold times in ms
  localparam logic [5:0] HOLD_STROBE = 6'd1;
  localparam logic [5:0] HOLD_SETTLE = 6'd10;
  localparam logic [5:0] HOLD_POWER  = 6'd50;

  // Program layout
  localparam int UC_DEPTH = 43;
  localparam int UC_AW    = 6;
  localparam logic [UC_AW-1:0] BYTE_ADDR = 6'd0;
  localparam logic [UC_AW-1:0] INIT_ADDR = 6'd6;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [1:0] row;
    logic [7:0] col;
  } req_item_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       reg_select;
    logic       enable_line;
    logic [5:0] hold_ms;
    logic       last;
  } pin_item_t;

  // Where a step's nibble comes from
  typedef enum logic [1:0] {
    SRC_HI,
    SRC_LO,
    SRC_CONST
  } nib_src_t;

  // One control word
  typedef struct packed {
    nib_src_t   src;
    logic [3:0] nib;
    logic       en;
    logic [5:0] hold;
    logic       last;
  } ucode_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic   load;
    logic   emit;
    ucode_t word;
  } dp_ctl_t;

  function automatic ucode_t uc(nib_src_t src, logic [3:0] nib, logic en,
                                logic [5:0] hold, logic last);
    ucode_t w;
    w.src  = src;
    w.nib  = nib;
    w.en   = en;
    w.hold = hold;
    w.last = last;
    return w;
  endfunction

  // Program: byte write at BYTE_ADDR, init run at INIT_ADDR
  localparam ucode_t UCODE [UC_DEPTH] = '{
    // byte write, high nibble then low nibble
    uc(SRC_HI, 4'h0, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_HI, 4'h0, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_HI, 4'h0, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_LO, 4'h0, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_LO, 4'h0, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_LO, 4'h0, 1'b0, HOLD_SETTLE, 1'b1),
    // init: power-up wait
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_POWER, 1'b0),
    // single nibbles 3, 3, 3, 2
    uc(SRC_CONST, 4'h3, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h3, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'h2, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h2, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h2, 1'b0, HOLD_SETTLE, 1'b0),
    // function set 0x28
    uc(SRC_CONST, 4'h2, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h2, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h2, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'h8, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h8, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h8, 1'b0, HOLD_SETTLE, 1'b0),
    // display on, cursor blink 0x0F
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h0, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'hF, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'hF, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'hF, 1'b0, HOLD_SETTLE, 1'b0),
    // clear 0x01
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h0, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'h1, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h1, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h1, 1'b0, HOLD_SETTLE, 1'b0),
    // entry mode 0x06
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h0, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h0, 1'b0, HOLD_SETTLE, 1'b0),
    uc(SRC_CONST, 4'h6, 1'b0, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h6, 1'b1, HOLD_STROBE, 1'b0),
    uc(SRC_CONST, 4'h6, 1'b0, HOLD_SETTLE, 1'b1)
  };

endpackage

### rtl/lcdnws_ctrl.sv
// Microcode sequencer: step counter, dispatch on opcode, fetch from UCODE.
// Depends on lcdnws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdnws_ctrl
  import lcdnws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] op,
  input  logic       out_room,
  output logic       in_stall,
  output dp_ctl_t    ctl
);

  logic             busy;
  logic             busy_next;
  logic [UC_AW-1:0] pc;
  logic [UC_AW-1:0] pc_next;
  ucode_t           word;
  logic             emit;
  logic             start;

  // Fetch
  assign word = UCODE[pc];
  assign emit = busy && out_room;

  // Free for a new item when idle or when the final step goes out now
  assign in_stall = busy && !(emit && word.last);
  assign start    = in_valid && !in_stall;

  // Next step: dispatch on accept, advance on emit
  always_comb begin
    busy_next = busy;
    pc_next   = pc;
    if (start) begin
      busy_next = 1'b1;
      pc_next   = (op == OP_INIT) ? INIT_ADDR : BYTE_ADDR;
    end else if (emit) begin
      if (word.last) begin
        busy_next = 1'b0;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= BYTE_ADDR;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  assign ctl.load = start;
  assign ctl.emit = emit;
  assign ctl.word = word;

  `LCDNWS_ASSERT_IMPL(a_pc_in_program, busy, pc < UC_AW'(UC_DEPTH), "pc ran past program")
  `LCDNWS_ASSERT_NEXT(a_mid_run_busy, emit && !word.last, busy, "run ended before last step")
  `LCDNWS_ASSERT_NEXT(a_start_busy, start, busy && (pc == BYTE_ADDR || pc == INIT_ADDR),
                      "bad dispatch target")

endmodule

### rtl/lcdnws_dp.sv
// Datapath: byte and register-select latches, nibble select, output register.
// Depends on lcdnws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdnws_dp
  import lcdnws_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  req_item_t in_item,
  input  dp_ctl_t   ctl,
  input  logic      out_stall,
  output logic      out_room,
  output logic      out_valid,
  output pin_item_t out_item
);

  logic [7:0] byte_q;
  logic       rs_q;
  logic [7:0] cursor_base;
  logic [7:0] load_byte;
  logic [3:0] nib;

  // Byte to send: data, or cursor address for a cursor move
  assign cursor_base = (in_item.row == ROW_FIRST) ? ROW_FIRST_BASE : ROW_OTHER_BASE;
  assign load_byte   = (in_item.op == OP_CURSOR) ? cursor_base + in_item.col : in_item.data;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      byte_q <= load_byte;
      rs_q   <= (in_item.op == OP_CHAR);
    end
  end

  // Nibble select per control word
  always_comb begin
    case (ctl.word.src)
      SRC_HI:  nib = byte_q[7:4];
      SRC_LO:  nib = byte_q[3:0];
      default: nib = ctl.word.nib;
    endcase
  end

  assign out_room = !out_valid || !out_stall;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_item.bus_nibble  <= nib;
      out_item.reg_select  <= (ctl.word.src == SRC_CONST) ? 1'b0 : rs_q;
      out_item.enable_line <= ctl.word.en;
      out_item.hold_ms     <= ctl.word.hold;
      out_item.last        <= ctl.word.last;
    end
  end

  `LCDNWS_ASSERT(a_no_overwrite, !(ctl.emit && out_valid && out_stall),
                 "held item overwritten")
  `LCDNWS_ASSERT_NEXT(a_emit_valid, ctl.emit, out_valid, "emitted item not valid")
  `LCDNWS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_item),
                      "stalled item changed")

endmodule

### rtl/lcd_nibble_write_sequencer.sv
// Character LCD 4-bit bus sequencer, top level.
// Input channel (in_valid / in_stall / in_item) takes one request: a command
// byte, a character byte, a cursor move or the init run.
// Output channel (out_valid / out_stall / out_item) gives the pin states of
// that request in order, each with its hold time in ms; last marks the end.
// Byte requests give 6 pin states, init gives 37 (a 50 ms wait, four single
// nibbles, four command bytes).
// Throughput: one pin state per cycle while out_stall is low; the next request
// is taken in the cycle its predecessor's final pin state enters the output
// register. The rate is set by the microcode step counter, which fetches one
// control word a cycle while the output register has room.
// A stall on the output freezes the step counter and holds the output item;
// in_stall stays high until the run's last step is issued.
// Reset (rst, synchronous) idles the sequencer and drops out_valid.
// Depends on lcdnws_pkg, lcdnws_ctrl and lcdnws_dp.
module lcd_nibble_write_sequencer
  import lcdnws_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  req_item_t in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output pin_item_t out_item
);

  dp_ctl_t ctl;
  logic    out_room;

  // Step sequencer
  lcdnws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (in_item.op),
    .out_room (out_room),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // Datapath and output register
  lcdnws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .ctl       (ctl),
    .out_stall (out_stall),
    .out_room  (out_room),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### sim/testbench.sv
// Self-checking bench for the LCD nibble write sequencer: random requests under varying
// sender gaps and receiver stalls, with every pin state checked against a local predictor.
// Depends on lcdnws_pkg and lcd_nibble_write_sequencer from the rtl folder.
`timescale 1ns / 1ps

module testbench;
  import lcdnws_pkg::*;

  // Init run constants: wake-up nibble, 4-bit mode nibble, then four setup commands
  localparam logic [3:0] WAKE_NIB   = 4'h3;
  localparam logic [3:0] MODE4_NIB  = 4'h2;
  localparam logic [7:0] FUNC_SET   = 8'h28;
  localparam logic [7:0] DISP_ON    = 8'h0F;
  localparam logic [7:0] DISP_CLEAR = 8'h01;
  localparam logic [7:0] ENTRY_MODE = 8'h06;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  req_item_t in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pin_item_t out_item;

  req_item_t req_q[$];
  pin_item_t pin_expect_q[$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  reqs_queued = 0;
  int  reqs_taken = 0;
  int  pins_checked = 0;
  int  mismatches = 0;
  int  init_reqs = 0;
  int  cursor_reqs = 0;
  logic req_taken = 1'b0;

  lcd_nibble_write_sequencer DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Pin state predictor
  function automatic void push_pin(logic [3:0] nib, logic rs, logic en, logic [5:0] hold);
    pin_item_t p;
    p.bus_nibble  = nib;
    p.reg_select  = rs;
    p.enable_line = en;
    p.hold_ms     = hold;
    p.last        = 1'b0;
    pin_expect_q.push_back(p);
  endfunction

  // One nibble: strobe low, strobe high, then settle
  function automatic void push_nibble(logic [3:0] nib, logic rs);
    push_pin(nib, rs, 1'b0, HOLD_STROBE);
    push_pin(nib, rs, 1'b1, HOLD_STROBE);
    push_pin(nib, rs, 1'b0, HOLD_SETTLE);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic rs);
    push_nibble(b[7:4], rs);
    push_nibble(b[3:0], rs);
  endfunction

  function automatic void predict_pin_states(req_item_t req);
    pin_item_t tail;
    logic [7:0] addr_cmd;
    case (req.op)
      OP_CMD:  push_byte(req.data, 1'b0);
      OP_CHAR: push_byte(req.data, 1'b1);
      OP_CURSOR: begin
        // base + column, wrapped to a byte
        addr_cmd = (req.row == ROW_FIRST) ? ROW_FIRST_BASE + req.col
                                          : ROW_OTHER_BASE + req.col;
        push_byte(addr_cmd, 1'b0);
      end
      default: begin
        push_pin(4'h0, 1'b0, 1'b0, HOLD_POWER);
        push_nibble(WAKE_NIB, 1'b0);
        push_nibble(WAKE_NIB, 1'b0);
        push_nibble(WAKE_NIB, 1'b0);
        push_nibble(MODE4_NIB, 1'b0);
        push_byte(FUNC_SET, 1'b0);
        push_byte(DISP_ON, 1'b0);
        push_byte(DISP_CLEAR, 1'b0);
        push_byte(ENTRY_MODE, 1'b0);
      end
    endcase
    // mark end of request
    tail = pin_expect_q.pop_back();
    tail.last = 1'b1;
    pin_expect_q.push_back(tail);
  endfunction

  // Request queueing
  task automatic queue_req(logic [1:0] op, logic [7:0] data, logic [1:0] row, logic [7:0] col);
    req_item_t r;
    r.op   = op;
    r.data = data;
    r.row  = row;
    r.col  = col;
    req_q.push_back(r);
    reqs_queued++;
    if (op == OP_INIT) init_reqs++;
    if (op == OP_CURSOR) cursor_reqs++;
  endtask

  task automatic queue_random_reqs(int count);
    int pick;
    logic [1:0] op;
    logic [7:0] col;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 33) op = OP_CMD;
      else if (pick < 63) op = OP_CHAR;
      else if (pick < 92) op = OP_CURSOR;
      else op = OP_INIT;
      // columns mostly on screen, sometimes anywhere
      col = ($urandom_range(3) != 0) ? 8'($urandom_range(16, 1)) : 8'($urandom_range(255));
      queue_req(op, 8'($urandom), 2'($urandom_range(3)), col);
    end
  endtask

  task automatic run_phase(int count, int send_pct, int stall_in_pct);
    send_idle_pct = send_pct;
    stall_pct = stall_in_pct;
    queue_random_reqs(count);
    while (reqs_taken != reqs_queued) @(posedge clk);
  endtask

  // Driver: new values at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Monitor: predict on request accept, check on pin state accept
  always @(posedge clk) begin : monitor
    pin_item_t want;
    req_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_pin_states(in_item);
        reqs_taken++;
      end
      if (out_valid && !out_stall) begin
        if (pin_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected pin state %h/%b/%b/%0d/%b", $realtime,
                     out_item.bus_nibble, out_item.reg_select, out_item.enable_line,
                     out_item.hold_ms, out_item.last);
        end else begin
          want = pin_expect_q.pop_front();
          pins_checked++;
          if (out_item.bus_nibble !== want.bus_nibble || out_item.reg_select !== want.reg_select
              || out_item.enable_line !== want.enable_line || out_item.hold_ms !== want.hold_ms
              || out_item.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: pin %0d exp %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
                       $realtime, pins_checked, want.bus_nibble, want.reg_select,
                       want.enable_line, want.hold_ms, want.last, out_item.bus_nibble,
                       out_item.reg_select, out_item.enable_line, out_item.hold_ms,
                       out_item.last);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("lcd_nibble_write_sequencer regression: fail");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    int guard;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, every op, cursor wrap on both rows, init with junk fields
    queue_req(OP_CMD, 8'h00, 2'd0, 8'h00);
    queue_req(OP_CMD, 8'hFF, 2'd3, 8'hFF);
    queue_req(OP_CMD, 8'hA5, 2'd1, 8'h01);
    queue_req(OP_CHAR, 8'h00, 2'd0, 8'h00);
    queue_req(OP_CHAR, 8'hFF, 2'd3, 8'hFF);
    queue_req(OP_CHAR, 8'h5A, 2'd2, 8'h10);
    queue_req(OP_CURSOR, 8'hFF, 2'd1, 8'd1);
    queue_req(OP_CURSOR, 8'h00, 2'd1, 8'd16);
    queue_req(OP_CURSOR, 8'h00, 2'd1, 8'd0);
    queue_req(OP_CURSOR, 8'h00, 2'd1, 8'h81);
    queue_req(OP_CURSOR, 8'h00, 2'd1, 8'hFF);
    queue_req(OP_CURSOR, 8'h00, 2'd0, 8'd1);
    queue_req(OP_CURSOR, 8'h00, 2'd2, 8'd16);
    queue_req(OP_CURSOR, 8'h00, 2'd3, 8'h41);
    queue_req(OP_CURSOR, 8'hFF, 2'd3, 8'hFF);
    queue_req(OP_CURSOR, 8'h00, 2'd0, 8'h00);
    queue_req(OP_INIT, 8'h00, 2'd0, 8'h00);
    queue_req(OP_INIT, 8'hFF, 2'd3, 8'hFF);
    queue_req(OP_CHAR, 8'h41, 2'd0, 8'h00);
    queue_req(OP_INIT, 8'h5A, 2'd1, 8'h0F);
    while (reqs_taken != reqs_queued) @(posedge clk);

    run_phase(75, 0, 0);
    run_phase(75, 47, 0);
    run_phase(75, 0, 47);
    run_phase(75, 32, 32);

    // drain
    guard = 0;
    while (pin_expect_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pin_expect_q.size() != 0) begin
      mismatches++;
      $display("%0d expected pin states never arrived", pin_expect_q.size());
    end

    $display("Covered %0d requests (%0d init runs, %0d cursor moves), %0d pin states checked,",
             reqs_taken, init_reqs, cursor_reqs, pins_checked);
    $display("across idle-free, sender-gap, receiver-stall and mixed phases; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("lcd_nibble_write_sequencer regression: pass");
    end else begin
      $display("lcd_nibble_write_sequencer regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lcdnws_pkg.sv
rtl/lcdnws_ctrl.sv
rtl/lcdnws_dp.sv
rtl/lcd_nibble_write_sequencer.sv
sim/testbench.sv
